@@ rtl/sqlcs_pkg.sv @@
// Shared constants and types for the SQL literal and comment stripper.
// Depends on nothing; imported by sql_literal_comment_stripper_unit.
package sqlcs_pkg;

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Results one input byte can cause, and the depth of the result queue.
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       no_byte;
      logic       end_of_text;
   } result_type;

endpackage

@@ rtl/sql_literal_comment_stripper_unit.sv @@
// Top level of the SQL literal and comment stripper: byte scanner and result queue.
// Depends on sqlcs_pkg for character codes and the result record.

// One byte of SQL text is taken per transfer; its results go into a registered
// queue. The scanner decides everything for a byte in the cycle it is transferred
// and pushes between zero and three results into a four-entry result queue that
// drains one result per cycle while rsp_ready is high. A new byte is taken whenever
// the queue holds at most one result, so text whose bytes cause at most one result
// each streams at one byte per cycle while the receiver keeps up; a byte causing
// two or three results (a flushed dash or slash, the end marker on the last byte)
// holds off new bytes as the queue drains. Quoted literals collapse to one space,
// "--" comments to one space plus their newline, block comments to one space plus
// every newline inside, and the last byte of a text ends with an end-marker result.
module sql_literal_comment_stripper_unit
   import sqlcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_no_byte,
   output logic       rsp_end_of_text
);

   typedef enum logic [3:0] {
      M_TEXT       = 4'd0,
      M_TEXT_DASH  = 4'd1,
      M_TEXT_SLASH = 4'd2,
      M_SQ         = 4'd3,
      M_SQ_QUOTE   = 4'd4,
      M_DQ         = 4'd5,
      M_DQ_QUOTE   = 4'd6,
      M_LINE       = 4'd7,
      M_BLOCK      = 4'd8,
      M_BLOCK_STAR = 4'd9
   } mode_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] ch;
      mode_type   mode;
   } plain_type;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_W = $clog2(MAX_RESULTS + 1);

   mode_type   mode_ff, mode_in;
   result_type queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   result_type res    [MAX_RESULTS];
   logic [NUM_W-1:0] res_num;
   logic       accept, pop;
   plain_type  pl;

   // Plain text with nothing pending.
   function automatic plain_type plain_step(input logic [7:0] c);
      plain_type p;
      p.emit = 1'b1;
      p.ch   = CH_SPACE;
      p.mode = M_TEXT;
      priority if (c == CH_SQUOTE) begin
         p.mode = M_SQ;
      end else if (c == CH_DQUOTE) begin
         p.mode = M_DQ;
      end else if (c == CH_DASH) begin
         p.emit = 1'b0;
         p.mode = M_TEXT_DASH;
      end else if (c == CH_SLASH) begin
         p.emit = 1'b0;
         p.mode = M_TEXT_SLASH;
      end else begin
         p.ch = c;
      end
      return p;
   endfunction

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
   assign rsp_valid = (count_ff != '0);

   assign rsp_out_byte    = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_no_byte     = queue_ff[rd_ptr_ff].no_byte;
   assign rsp_end_of_text = queue_ff[rd_ptr_ff].end_of_text;

   always_comb begin
      logic [7:0] c;
      c       = req_text_byte;
      res_num = '0;
      mode_in = mode_ff;
      pl      = plain_step(c);
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '{out_byte: CH_SPACE, no_byte: 1'b0, end_of_text: 1'b0};
      end

      unique case (mode_ff)
         M_TEXT_DASH: begin
            res[res_num] = '{out_byte: (c == CH_DASH) ? CH_SPACE : CH_DASH,
                             no_byte: 1'b0, end_of_text: 1'b0};
            res_num = res_num + NUM_W'(1);
            if (c == CH_DASH) begin
               mode_in = M_LINE;
            end else begin
               if (pl.emit) begin
                  res[res_num].out_byte = pl.ch;
                  res_num = res_num + NUM_W'(1);
               end
               mode_in = pl.mode;
            end
         end
         M_TEXT_SLASH: begin
            res[res_num] = '{out_byte: (c == CH_STAR) ? CH_SPACE : CH_SLASH,
                             no_byte: 1'b0, end_of_text: 1'b0};
            res_num = res_num + NUM_W'(1);
            if (c == CH_STAR) begin
               mode_in = M_BLOCK;
            end else begin
               if (pl.emit) begin
                  res[res_num].out_byte = pl.ch;
                  res_num = res_num + NUM_W'(1);
               end
               mode_in = pl.mode;
            end
         end
         M_SQ: mode_in = (c == CH_SQUOTE) ? M_SQ_QUOTE : M_SQ;
         M_DQ: mode_in = (c == CH_DQUOTE) ? M_DQ_QUOTE : M_DQ;
         M_SQ_QUOTE, M_DQ_QUOTE: begin
            // A doubled quote stays inside the literal.
            if ((mode_ff == M_SQ_QUOTE && c == CH_SQUOTE) ||
                (mode_ff == M_DQ_QUOTE && c == CH_DQUOTE)) begin
               mode_in = (mode_ff == M_SQ_QUOTE) ? M_SQ : M_DQ;
            end else begin
               if (pl.emit) begin
                  res[res_num].out_byte = pl.ch;
                  res_num = res_num + NUM_W'(1);
               end
               mode_in = pl.mode;
            end
         end
         M_LINE: begin
            if (c == CH_NL) begin
               res[res_num].out_byte = CH_NL;
               res_num = res_num + NUM_W'(1);
               mode_in = M_TEXT;
            end
         end
         M_BLOCK, M_BLOCK_STAR: begin
            if (mode_ff == M_BLOCK_STAR && c == CH_SLASH) begin
               mode_in = M_TEXT;
            end else if (c == CH_STAR) begin
               mode_in = M_BLOCK_STAR;
            end else begin
               if (c == CH_NL) begin
                  res[res_num].out_byte = CH_NL;
                  res_num = res_num + NUM_W'(1);
               end
               mode_in = M_BLOCK;
            end
         end
         default: begin
            if (pl.emit) begin
               res[res_num].out_byte = pl.ch;
               res_num = res_num + NUM_W'(1);
            end
            mode_in = pl.mode;
         end
      endcase

      // Last byte: flush a pending dash or slash, then give the end marker.
      if (req_is_final) begin
         if (mode_in == M_TEXT_DASH || mode_in == M_TEXT_SLASH) begin
            res[res_num].out_byte = (mode_in == M_TEXT_DASH) ? CH_DASH : CH_SLASH;
            res_num = res_num + NUM_W'(1);
         end
         res[res_num] = '{out_byte: 8'h00, no_byte: 1'b1, end_of_text: 1'b1};
         res_num = res_num + NUM_W'(1);
         mode_in = M_TEXT;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) count_in = count_in + CNT_W'(res_num);
      if (pop)    count_in = count_in - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_TEXT;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (accept) begin
            mode_ff   <= mode_in;
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(res_num);
         end
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (NUM_W'(i) < res_num) begin
               queue_ff[wr_ptr_ff + PTR_W'(i)] <= res[i];
            end
         end
      end
   end

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for sql_literal_comment_stripper_unit: SQL text goes in
// byte by byte, and a scanner model in this file predicts every cleaned byte.
// Depends on sqlcs_pkg for the character codes and the result record.
module tb_top;
   import sqlcs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 80;

   typedef enum logic [3:0] {
      SCAN_TEXT,
      SCAN_DASH,
      SCAN_SLASH,
      SCAN_SQ,
      SCAN_SQ_QUOTE,
      SCAN_DQ,
      SCAN_DQ_QUOTE,
      SCAN_LINE,
      SCAN_BLOCK,
      SCAN_BLOCK_STAR
   } scan_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_is_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_no_byte;
   logic       rsp_end_of_text;

   scan_mode_type scan_mode = SCAN_TEXT;
   result_type cleaned_queue[$];
   logic [7:0] text_buf[$];

   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int error_count   = 0;
   int bytes_sent    = 0;
   int results_seen  = 0;
   int texts_sent    = 0;
   int cycle_count   = 0;

   sql_literal_comment_stripper_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_is_final    (req_is_final),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_no_byte     (rsp_no_byte),
      .rsp_end_of_text (rsp_end_of_text)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- scanner model

   function automatic void push_cleaned(logic [7:0] b, logic nob, logic eot);
      cleaned_queue.insert(cleaned_queue.size(),
                           result_type'{out_byte: b, no_byte: nob, end_of_text: eot});
   endfunction

   function automatic scan_mode_type plain_step(logic [7:0] c);
      if (c == CH_SQUOTE) begin
         push_cleaned(CH_SPACE, 1'b0, 1'b0);
         return SCAN_SQ;
      end
      if (c == CH_DQUOTE) begin
         push_cleaned(CH_SPACE, 1'b0, 1'b0);
         return SCAN_DQ;
      end
      if (c == CH_DASH) return SCAN_DASH;
      if (c == CH_SLASH) return SCAN_SLASH;
      push_cleaned(c, 1'b0, 1'b0);
      return SCAN_TEXT;
   endfunction

   function automatic scan_mode_type block_step(logic [7:0] c);
      if (c == CH_STAR) return SCAN_BLOCK_STAR;
      if (c == CH_NL) push_cleaned(CH_NL, 1'b0, 1'b0);
      return SCAN_BLOCK;
   endfunction

   function automatic void predict_text_byte(logic [7:0] c, logic fin);
      scan_mode_type m;
      m = scan_mode;
      case (m)
         SCAN_DASH: begin
            if (c == CH_DASH) begin
               push_cleaned(CH_SPACE, 1'b0, 1'b0);
               m = SCAN_LINE;
            end else begin
               push_cleaned(CH_DASH, 1'b0, 1'b0);
               m = plain_step(c);
            end
         end
         SCAN_SLASH: begin
            if (c == CH_STAR) begin
               push_cleaned(CH_SPACE, 1'b0, 1'b0);
               m = SCAN_BLOCK;
            end else begin
               push_cleaned(CH_SLASH, 1'b0, 1'b0);
               m = plain_step(c);
            end
         end
         SCAN_SQ:         m = (c == CH_SQUOTE) ? SCAN_SQ_QUOTE : SCAN_SQ;
         SCAN_SQ_QUOTE:   m = (c == CH_SQUOTE) ? SCAN_SQ : plain_step(c);
         SCAN_DQ:         m = (c == CH_DQUOTE) ? SCAN_DQ_QUOTE : SCAN_DQ;
         SCAN_DQ_QUOTE:   m = (c == CH_DQUOTE) ? SCAN_DQ : plain_step(c);
         SCAN_LINE: begin
            if (c == CH_NL) begin
               push_cleaned(CH_NL, 1'b0, 1'b0);
               m = SCAN_TEXT;
            end
         end
         SCAN_BLOCK:      m = block_step(c);
         SCAN_BLOCK_STAR: m = (c == CH_SLASH) ? SCAN_TEXT : block_step(c);
         default:         m = plain_step(c);
      endcase
      if (fin) begin
         // flush a held dash or slash, then close the text with the end marker
         if (m == SCAN_DASH) push_cleaned(CH_DASH, 1'b0, 1'b0);
         if (m == SCAN_SLASH) push_cleaned(CH_SLASH, 1'b0, 1'b0);
         push_cleaned(8'h00, 1'b1, 1'b1);
         m = SCAN_TEXT;
      end
      scan_mode = m;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_result();
      result_type exp_res;
      results_seen++;
      if (cleaned_queue.size() == 0) begin
         report_error($sformatf("unexpected result byte %02h no_byte %0b end %0b",
                                rsp_out_byte, rsp_no_byte, rsp_end_of_text));
      end else begin
         exp_res = cleaned_queue.pop_front();
         if (rsp_out_byte !== exp_res.out_byte)
            report_error($sformatf("out_byte %02h, wanted %02h",
                                   rsp_out_byte, exp_res.out_byte));
         if (rsp_no_byte !== exp_res.no_byte)
            report_error($sformatf("no_byte %0b, wanted %0b",
                                   rsp_no_byte, exp_res.no_byte));
         if (rsp_end_of_text !== exp_res.end_of_text)
            report_error($sformatf("end_of_text %0b, wanted %0b",
                                   rsp_end_of_text, exp_res.end_of_text));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_text_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid     <= 1'b0;
         req_text_byte <= 8'($urandom);
         req_is_final  <= 1'($urandom);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_is_final  <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_text_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_text_byte(s[i], i == s.len() - 1);
      texts_sent++;
   endtask

   // Hold the sender off until every predicted result has been transferred.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (cleaned_queue.size() != 0) @(posedge clock);
   endtask

   function automatic void append_byte(logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   function automatic logic [7:0] pick_content_byte();
      logic [7:0] specials[5];
      specials = '{CH_SQUOTE, CH_DQUOTE, CH_DASH, CH_SLASH, CH_STAR};
      case ($urandom_range(0, 7))
         4:       return CH_SPACE;
         5:       return CH_NL;
         6:       return specials[$urandom_range(0, 4)];
         7:       return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   // Append one lexical piece of SQL to text_buf; mostly well-formed pieces.
   task automatic add_token();
      logic [7:0] quote;
      logic [7:0] b;
      int n;
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 9))
         0, 1: begin
            for (int i = 0; i <= n; i++) append_byte(8'($urandom_range(8'h41, 8'h5A)));
         end
         2, 3: begin
            quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            append_byte(quote);
            for (int i = 0; i < n; i++) begin
               b = ($urandom_range(0, 4) == 0) ? quote : pick_content_byte();
               append_byte(b);
               // double a quote so the literal stays open
               if (b == quote) append_byte(quote);
            end
            append_byte(quote);
         end
         4: begin
            append_byte(CH_DASH);
            append_byte(CH_DASH);
            for (int i = 0; i < n; i++) begin
               b = pick_content_byte();
               append_byte((b == CH_NL) ? CH_SPACE : b);
            end
            append_byte(CH_NL);
         end
         5: begin
            append_byte(CH_SLASH);
            append_byte(CH_STAR);
            for (int i = 0; i < n; i++) begin
               b = ($urandom_range(0, 3) == 0) ? CH_STAR : pick_content_byte();
               // keep the comment from closing early
               if (b == CH_SLASH && text_buf[$] == CH_STAR) b = 8'h78;
               append_byte(b);
            end
            append_byte(CH_STAR);
            append_byte(CH_SLASH);
         end
         6:       append_byte($urandom_range(0, 1) ? CH_DASH : CH_SLASH);
         7:       append_byte(8'($urandom_range(0, 255)));
         8:       append_byte(pick_content_byte());
         default: append_byte($urandom_range(0, 1) ? CH_NL : CH_SPACE);
      endcase
   endtask

   task automatic run_random_texts(input int target);
      int start;
      bit paused;
      start  = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start < target) begin
         text_buf.delete();
         repeat ($urandom_range(1, 6)) add_token();
         for (int i = 0; i < text_buf.size(); i++)
            send_text_byte(text_buf[i], i == text_buf.size() - 1);
         texts_sent++;
         if (!paused && bytes_sent - start >= target / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'hFF, 1'b1);
      texts_sent++;
      send_text("'a''b'-");
      send_text("-x/y--\n/");
      send_text("\"d\"");
      send_text("/*\n**");
      wait_for_drain();
   endtask

   task automatic test_streaming();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      run_random_texts(PHASE_ITEMS);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 48;
      rcv_stall_pct = 0;
      run_random_texts(PHASE_ITEMS);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      rcv_stall_pct = 48;
      run_random_texts(PHASE_ITEMS);
   endtask

   task automatic test_mixed_idle();
      send_idle_pct = 38;
      rcv_stall_pct = 38;
      run_random_texts(PHASE_ITEMS);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idle();

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (cleaned_queue.size() != 0)
         report_error($sformatf("%0d results never arrived", cleaned_queue.size()));

      $display("Covered %0d texts, %0d bytes in, %0d results checked, %0d mismatches",
               texts_sent, bytes_sent, results_seen, error_count);
      $display("Traffic ran with no idling, sender gaps, receiver stalls and both mixed");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
